// ----- sv/cad_pkg.sv -----
// Shared types and constants of the count array stream decoder.
`timescale 1ns / 1ps

package cad_pkg;

    localparam int BYTE_W      = 8;
    localparam int VALUE_W     = 64;
    localparam int STATUS_W    = 3;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 8;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_VARINT_CODE = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WORD_CODE   = 1'd1;

    localparam logic [BYTE_W-1:0] VARINT_CODE_RESET = 8'd0;
    localparam logic [BYTE_W-1:0] WORD_CODE_RESET   = 8'd1;

    // Done status codes.
    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_HEADER = 3'd1;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_SHORT_WORD = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_VARINT = 3'd4;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              byte_present;
        logic              end_of_buffer;
    } in_word_t;

    typedef struct packed {
        logic [VALUE_W-1:0]  element_value;
        logic                element_valid;
        logic [VALUE_W-1:0]  element_index;
        logic                done_res;
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  element_total;
    } result_t;

    typedef struct packed {
        logic                   we;
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  data;
    } cfg_write_t;

endpackage

// ----- sv/cad_if.sv -----
// Valid/ready channel interfaces for the input and result streams.
`timescale 1ns / 1ps

interface cad_in_if;
    logic                       valid;
    logic                       ready;
    logic [cad_pkg::BYTE_W-1:0] data_byte;
    logic                       byte_present;
    logic                       end_of_buffer;

    modport source (output valid, output data_byte, output byte_present,
                    output end_of_buffer, input ready);
    modport sink (input valid, input data_byte, input byte_present,
                  input end_of_buffer, output ready);
endinterface

interface cad_out_if;
    logic                         valid;
    logic                         ready;
    logic [cad_pkg::VALUE_W-1:0]  element_value;
    logic                         element_valid;
    logic [cad_pkg::VALUE_W-1:0]  element_index;
    logic                         done_res;
    logic [cad_pkg::STATUS_W-1:0] status;
    logic [cad_pkg::VALUE_W-1:0]  element_total;

    modport source (output valid, output element_value, output element_valid,
                    output element_index, output done_res, output status,
                    output element_total, input ready);
    modport sink (input valid, input element_value, input element_valid,
                  input element_index, input done_res, input status,
                  input element_total, output ready);
endinterface

// ----- sv/cad_in_stage.sv -----
// Input register holding one accepted word until the decoder takes it.
`timescale 1ns / 1ps

module cad_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    cad_in_if.sink            in_stream,
    input  logic              take,
    output logic              word_valid,
    output cad_pkg::in_word_t word
);

    logic              valid_reg;
    logic              valid_next;
    cad_pkg::in_word_t word_reg;
    logic              accept;

    // The slot is free when empty or when its word is consumed this cycle.
    assign in_stream.ready = !valid_reg || take;
    assign accept          = in_stream.valid && in_stream.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            word_reg.data_byte     <= in_stream.data_byte;
            word_reg.byte_present  <= in_stream.byte_present;
            word_reg.end_of_buffer <= in_stream.end_of_buffer;
        end
    end

    assign word_valid = valid_reg;
    assign word       = word_reg;

endmodule

// ----- sv/cad_core.sv -----
// Decoder state and the single-pass update for one buffer word.
`timescale 1ns / 1ps

module cad_core (
    input  logic                clk,
    input  logic                rst_n,
    input  cad_pkg::cfg_write_t cfg,
    input  logic                take,
    input  cad_pkg::in_word_t   word,
    output logic                res_has,
    output cad_pkg::result_t    res
);

    localparam logic [2:0] PH_FORMAT   = 3'd0;
    localparam logic [2:0] PH_HEADER   = 3'd1;
    localparam logic [2:0] PH_PAY_VAR  = 3'd2;
    localparam logic [2:0] PH_PAY_WORD = 3'd3;
    localparam logic [2:0] PH_DRAIN    = 3'd4;

    localparam int VW = cad_pkg::VALUE_W;

    logic [cad_pkg::BYTE_W-1:0]   varint_code_reg;
    logic [cad_pkg::BYTE_W-1:0]   word_code_reg;

    logic [2:0]                   phase_reg,  phase_next;
    logic [cad_pkg::BYTE_W-1:0]   format_reg, format_next;
    logic [VW-1:0]                total_reg,  total_next;
    logic [VW-1:0]                index_reg,  index_next;
    logic [VW-1:0]                acc_reg,    acc_next;
    logic [3:0]                   pos_reg,    pos_next;
    logic [cad_pkg::STATUS_W-1:0] err_reg,    err_next;

    logic [6:0]    leb_shift;
    logic [VW-1:0] leb_acc;
    logic          leb_err;
    logic          leb_cont;
    logic [VW-1:0] word_acc;
    logic [VW-1:0] index_inc;
    logic          have_elem;
    logic [VW-1:0] elem_val;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            varint_code_reg <= cad_pkg::VARINT_CODE_RESET;
            word_code_reg   <= cad_pkg::WORD_CODE_RESET;
        end
        else if (cfg.we)
        begin
            unique case (cfg.index)
                cad_pkg::REG_VARINT_CODE: varint_code_reg <= cfg.data;
                cad_pkg::REG_WORD_CODE:   word_code_reg   <= cfg.data;
                default: ;
            endcase
        end
    end

    // LEB128 byte: seven payload bits land at 7 * position. The tenth byte
    // may only carry the top bit of a 64-bit value and must end the varint.
    assign leb_shift = ({3'b000, pos_reg} << 3) - {3'b000, pos_reg};
    assign leb_acc   = acc_reg | ({57'd0, word.data_byte[6:0]} << leb_shift);
    assign leb_cont  = word.data_byte[7];
    assign leb_err   = (pos_reg > 4'd9)
                    || ((pos_reg == 4'd9) && ((word.data_byte[6:1] != 6'd0) || leb_cont));

    assign word_acc  = acc_reg | ({56'd0, word.data_byte} << {pos_reg[1:0], 3'b000});
    assign index_inc = index_reg + 64'd1;

    always_comb
    begin
        phase_next  = phase_reg;
        format_next = format_reg;
        total_next  = total_reg;
        index_next  = index_reg;
        acc_next    = acc_reg;
        pos_next    = pos_reg;
        err_next    = err_reg;
        have_elem   = 1'b0;
        elem_val    = '0;
        res         = '0;

        if (word.byte_present)
        begin
            unique case (phase_reg)
                PH_FORMAT:
                begin
                    format_next = word.data_byte;
                    phase_next  = PH_HEADER;
                    acc_next    = '0;
                    pos_next    = '0;
                end
                PH_HEADER:
                begin
                    if (leb_err)
                    begin
                        total_next = '0;
                        phase_next = PH_DRAIN;
                        err_next   = cad_pkg::ST_BAD_HEADER;
                        acc_next   = '0;
                        pos_next   = '0;
                    end
                    else if (leb_cont)
                    begin
                        acc_next = leb_acc;
                        pos_next = pos_reg + 4'd1;
                    end
                    else
                    begin
                        total_next = leb_acc;
                        index_next = '0;
                        acc_next   = '0;
                        pos_next   = '0;
                        if (format_reg == varint_code_reg)
                        begin
                            phase_next = PH_PAY_VAR;
                        end
                        else if (format_reg == word_code_reg)
                        begin
                            phase_next = PH_PAY_WORD;
                        end
                        else
                        begin
                            phase_next = PH_DRAIN;
                            err_next   = cad_pkg::ST_UNKNOWN;
                        end
                        // A known format with no elements finishes at once.
                        if (phase_next != PH_DRAIN && leb_acc == '0)
                        begin
                            phase_next = PH_DRAIN;
                            err_next   = cad_pkg::ST_OK;
                        end
                    end
                end
                PH_PAY_VAR:
                begin
                    if (leb_err)
                    begin
                        phase_next = PH_DRAIN;
                        err_next   = cad_pkg::ST_BAD_VARINT;
                        acc_next   = '0;
                        pos_next   = '0;
                    end
                    else if (leb_cont)
                    begin
                        acc_next = leb_acc;
                        pos_next = pos_reg + 4'd1;
                    end
                    else
                    begin
                        have_elem = 1'b1;
                        elem_val  = leb_acc;
                        acc_next  = '0;
                        pos_next  = '0;
                    end
                end
                PH_PAY_WORD:
                begin
                    if (pos_reg[1:0] == 2'd3)
                    begin
                        have_elem = 1'b1;
                        elem_val  = word_acc;
                        acc_next  = '0;
                        pos_next  = '0;
                    end
                    else
                    begin
                        acc_next = word_acc;
                        pos_next = {2'b00, pos_reg[1:0]} + 4'd1;
                    end
                end
                default: ;
            endcase

            if (have_elem)
            begin
                index_next = index_inc;
                if (index_inc == total_reg)
                begin
                    phase_next = PH_DRAIN;
                    err_next   = cad_pkg::ST_OK;
                    acc_next   = '0;
                    pos_next   = '0;
                end
            end
        end

        if (have_elem)
        begin
            res.element_value = elem_val;
            res.element_valid = 1'b1;
            res.element_index = index_reg;
        end

        if (word.end_of_buffer)
        begin
            res.done_res = 1'b1;
            unique case (phase_next)
                PH_FORMAT:
                begin
                    res.status        = cad_pkg::ST_OK;
                    res.element_total = '0;
                end
                PH_HEADER:
                begin
                    res.status        = cad_pkg::ST_BAD_HEADER;
                    res.element_total = '0;
                end
                PH_PAY_VAR:
                begin
                    res.status        = cad_pkg::ST_BAD_VARINT;
                    res.element_total = total_next;
                end
                PH_PAY_WORD:
                begin
                    res.status        = cad_pkg::ST_SHORT_WORD;
                    res.element_total = total_next;
                end
                default:
                begin
                    res.status        = err_next;
                    res.element_total = total_next;
                end
            endcase
            // The buffer is over: rearm for the next one.
            phase_next  = PH_FORMAT;
            format_next = '0;
            total_next  = '0;
            index_next  = '0;
            acc_next    = '0;
            pos_next    = '0;
            err_next    = cad_pkg::ST_OK;
        end
    end

    assign res_has = have_elem || word.end_of_buffer;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_FORMAT;
            format_reg <= '0;
            total_reg  <= '0;
            index_reg  <= '0;
            acc_reg    <= '0;
            pos_reg    <= '0;
            err_reg    <= cad_pkg::ST_OK;
        end
        else if (take)
        begin
            phase_reg  <= phase_next;
            format_reg <= format_next;
            total_reg  <= total_next;
            index_reg  <= index_next;
            acc_reg    <= acc_next;
            pos_reg    <= pos_next;
            err_reg    <= err_next;
        end
    end

endmodule

// ----- sv/cad_out_stage.sv -----
// Result register driving the output channel.
`timescale 1ns / 1ps

module cad_out_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  cad_pkg::result_t res,
    output logic             can_load,
    cad_out_if.source        out_stream
);

    logic             valid_reg;
    logic             valid_next;
    cad_pkg::result_t res_reg;

    // A new result may replace the held one in the cycle it is taken.
    assign can_load = !valid_reg || out_stream.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_stream.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign out_stream.valid         = valid_reg;
    assign out_stream.element_value = res_reg.element_value;
    assign out_stream.element_valid = res_reg.element_valid;
    assign out_stream.element_index = res_reg.element_index;
    assign out_stream.done_res      = res_reg.done_res;
    assign out_stream.status        = res_reg.status;
    assign out_stream.element_total = res_reg.element_total;

endmodule

// ----- sv/count_array_stream_decoder_top.sv -----
// Top level of the count array stream decoder.
//
// in_stream carries one buffer byte per word (or a bare end marker); the
// first byte is the format code, then a LEB128 element count, then the
// payload as LEB128 values or four-byte little-endian values.
// out_stream carries at most one result word per input word: a finished
// element with its index, the done status at the end of a buffer, or both.
// cfg_we/cfg_index/cfg_data write the two format code registers; write
// them only while no buffer is in flight.
// Each accepted word is held in the input register, decoded combinationally
// and, if it yields a result, loaded into the result register that drives
// out_stream.
// Throughput is one byte per cycle when not stalled; the only recurrence
// is the decoder state update, a 64-bit increment and compare per element.
// Reset clears both registers' valid flags and returns the decoder to the
// format byte; the format codes return to their defaults.
// When the receiver stalls, the held result stays put, the input register
// fills, and in_stream.ready drops until the result is taken.
`timescale 1ns / 1ps

module count_array_stream_decoder_top (
    input  logic                              clk,
    input  logic                              rst_n,
    cad_in_if.sink                            in_stream,
    cad_out_if.source                         out_stream,
    input  logic                              cfg_we,
    input  logic [cad_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [cad_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic                word_valid;
    cad_pkg::in_word_t   word;
    logic                take;
    logic                can_load;
    logic                res_has;
    cad_pkg::result_t    res;
    cad_pkg::cfg_write_t cfg;

    assign cfg.we    = cfg_we;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    assign take = word_valid && can_load;

    cad_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_stream  (in_stream),
        .take       (take),
        .word_valid (word_valid),
        .word       (word)
    );

    cad_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .take    (take),
        .word    (word),
        .res_has (res_has),
        .res     (res)
    );

    cad_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (take && res_has),
        .res        (res),
        .can_load   (can_load),
        .out_stream (out_stream)
    );

`ifndef SYNTHESIS
    // Every result word carries an element or a done status.
    a_result_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_stream.valid |-> (out_stream.element_valid || out_stream.done_res))
        else $error("result word with neither element nor done");

    // An element on the final byte with status ok must be the last element.
    a_last_elem_index: assert property (@(posedge clk) disable iff (!rst_n)
        (out_stream.valid && out_stream.element_valid && out_stream.done_res
         && out_stream.status == cad_pkg::ST_OK)
        |-> (out_stream.element_index + 64'd1 == out_stream.element_total))
        else $error("ok status with element not at the end of the array");

    // Done status stays within the defined codes.
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        (out_stream.valid && out_stream.done_res)
        |-> (out_stream.status <= cad_pkg::ST_BAD_VARINT))
        else $error("undefined done status");

    // A word is consumed only when the decoder has one and room for its result.
    a_take_gated: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> (word_valid && (!out_stream.valid || out_stream.ready)))
        else $error("decoder consumed a word without space for its result");
`endif

endmodule
